// File: hdl/quaternion_rotate_vector_core_assert.svh
// assertion macros for the quaternion rotation core checker
// expects i_clk and i_rst_n in the scope where the macros are used
`ifndef QUATERNION_ROTATE_VECTOR_CORE_ASSERT_SVH
`define QUATERNION_ROTATE_VECTOR_CORE_ASSERT_SVH

// labeled concurrent check, sampled on i_clk, off during reset
`define QRV_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// labeled check that a beat condition leads to a later result condition
`define QRV_CHECK_LAT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##(qrv_pkg::LATENCY) (cons)) else $error(msg);

`endif

// File: hdl/qrv_pkg.sv
// types and constants for the quaternion vector rotation core
// no dependencies
package qrv_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned PROD_W = 2 * DATA_W;
    localparam int unsigned P_W    = PROD_W + 2;
    localparam int unsigned SPLIT  = 33;
    localparam int unsigned LO_W   = SPLIT + 1 + DATA_W;
    localparam int unsigned HI_W   = P_W - SPLIT + DATA_W;
    localparam int unsigned SUM_W  = LO_W + 2;
    localparam int unsigned R_W    = 101;
    localparam int unsigned OUT_SH = 60;
    localparam int unsigned LATENCY = 6;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] quat_x;
        logic signed [DATA_W-1:0] quat_y;
        logic signed [DATA_W-1:0] quat_z;
        logic signed [DATA_W-1:0] quat_w;
        logic signed [DATA_W-1:0] vec_x;
        logic signed [DATA_W-1:0] vec_y;
        logic signed [DATA_W-1:0] vec_z;
    } t_qrv_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] rot_x;
        logic signed [DATA_W-1:0] rot_y;
        logic signed [DATA_W-1:0] rot_z;
        logic                     saturated;
    } t_qrv_out;

endpackage

// File: hdl/quaternion_rotate_vector_core.sv
// quaternion rotation of a vector: r = conj(q) * (v, 0) * q, vector part
// throughput: one beat per cycle, busy stays low, results cannot be held off
// six register stages: products, sums, split products, partial sums, merge, saturate
// synchronous active-low reset clears only the valid pipeline, data is not reset
// depends on qrv_pkg
module quaternion_rotate_vector_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  qrv_pkg::t_qrv_in i_item,
    output logic             o_valid,
    output qrv_pkg::t_qrv_out o_result
);

    typedef struct packed {
        logic signed [qrv_pkg::DATA_W-1:0] x;
        logic signed [qrv_pkg::DATA_W-1:0] y;
        logic signed [qrv_pkg::DATA_W-1:0] z;
        logic signed [qrv_pkg::DATA_W-1:0] w;
    } t_quat;

    logic [qrv_pkg::LATENCY-1:0] r_vld, n_vld;

    // stage 1
    logic signed [qrv_pkg::PROD_W-1:0] r_m [12];
    logic signed [qrv_pkg::PROD_W-1:0] n_m [12];
    t_quat r_q1, n_q1;
    // stage 2
    logic signed [qrv_pkg::P_W-1:0] r_p [4];
    logic signed [qrv_pkg::P_W-1:0] n_p [4];
    t_quat r_q2;
    // stage 3
    logic signed [qrv_pkg::LO_W-1:0] r_lo [12];
    logic signed [qrv_pkg::LO_W-1:0] n_lo [12];
    logic signed [qrv_pkg::HI_W-1:0] r_hi [12];
    logic signed [qrv_pkg::HI_W-1:0] n_hi [12];
    // stage 4
    logic signed [qrv_pkg::SUM_W-1:0] r_slo [3];
    logic signed [qrv_pkg::SUM_W-1:0] n_slo [3];
    logic signed [qrv_pkg::SUM_W-1:0] r_shi [3];
    logic signed [qrv_pkg::SUM_W-1:0] n_shi [3];
    // stage 5
    logic signed [qrv_pkg::R_W-1:0] r_r [3];
    logic signed [qrv_pkg::R_W-1:0] n_r [3];
    // stage 6
    qrv_pkg::t_qrv_out r_out, n_out;

    logic signed [qrv_pkg::P_W-1:0]    w_pa [12];
    logic signed [qrv_pkg::DATA_W-1:0] w_qa [12];
    logic signed [qrv_pkg::DATA_W-1:0] w_rot [3];
    logic [2:0]                        w_sat;

    assign busy = 1'b0;
    assign n_vld = {r_vld[qrv_pkg::LATENCY-2:0], start & ~busy};

    // conj(q) * (v, 0) products
    always_comb begin
        n_q1 = '{x: i_item.quat_x, y: i_item.quat_y, z: i_item.quat_z, w: i_item.quat_w};
        n_m[0]  = qrv_pkg::PROD_W'(i_item.quat_x) * qrv_pkg::PROD_W'(i_item.vec_x);
        n_m[1]  = qrv_pkg::PROD_W'(i_item.quat_y) * qrv_pkg::PROD_W'(i_item.vec_y);
        n_m[2]  = qrv_pkg::PROD_W'(i_item.quat_z) * qrv_pkg::PROD_W'(i_item.vec_z);
        n_m[3]  = qrv_pkg::PROD_W'(i_item.quat_w) * qrv_pkg::PROD_W'(i_item.vec_x);
        n_m[4]  = qrv_pkg::PROD_W'(i_item.quat_y) * qrv_pkg::PROD_W'(i_item.vec_z);
        n_m[5]  = qrv_pkg::PROD_W'(i_item.quat_z) * qrv_pkg::PROD_W'(i_item.vec_y);
        n_m[6]  = qrv_pkg::PROD_W'(i_item.quat_w) * qrv_pkg::PROD_W'(i_item.vec_y);
        n_m[7]  = qrv_pkg::PROD_W'(i_item.quat_z) * qrv_pkg::PROD_W'(i_item.vec_x);
        n_m[8]  = qrv_pkg::PROD_W'(i_item.quat_x) * qrv_pkg::PROD_W'(i_item.vec_z);
        n_m[9]  = qrv_pkg::PROD_W'(i_item.quat_w) * qrv_pkg::PROD_W'(i_item.vec_z);
        n_m[10] = qrv_pkg::PROD_W'(i_item.quat_x) * qrv_pkg::PROD_W'(i_item.vec_y);
        n_m[11] = qrv_pkg::PROD_W'(i_item.quat_y) * qrv_pkg::PROD_W'(i_item.vec_x);
    end

    // p = (pw, px, py, pz)
    always_comb begin
        n_p[0] = qrv_pkg::P_W'(r_m[0]) + qrv_pkg::P_W'(r_m[1]) + qrv_pkg::P_W'(r_m[2]);
        n_p[1] = qrv_pkg::P_W'(r_m[3]) - qrv_pkg::P_W'(r_m[4]) + qrv_pkg::P_W'(r_m[5]);
        n_p[2] = qrv_pkg::P_W'(r_m[6]) - qrv_pkg::P_W'(r_m[7]) + qrv_pkg::P_W'(r_m[8]);
        n_p[3] = qrv_pkg::P_W'(r_m[9]) - qrv_pkg::P_W'(r_m[10]) + qrv_pkg::P_W'(r_m[11]);
    end

    // p * q operand pairs, last of each group of four is subtracted
    always_comb begin
        w_pa[0]  = r_p[0]; w_qa[0]  = r_q2.x;
        w_pa[1]  = r_p[1]; w_qa[1]  = r_q2.w;
        w_pa[2]  = r_p[2]; w_qa[2]  = r_q2.z;
        w_pa[3]  = r_p[3]; w_qa[3]  = r_q2.y;
        w_pa[4]  = r_p[0]; w_qa[4]  = r_q2.y;
        w_pa[5]  = r_p[2]; w_qa[5]  = r_q2.w;
        w_pa[6]  = r_p[3]; w_qa[6]  = r_q2.x;
        w_pa[7]  = r_p[1]; w_qa[7]  = r_q2.z;
        w_pa[8]  = r_p[0]; w_qa[8]  = r_q2.z;
        w_pa[9]  = r_p[3]; w_qa[9]  = r_q2.w;
        w_pa[10] = r_p[1]; w_qa[10] = r_q2.y;
        w_pa[11] = r_p[2]; w_qa[11] = r_q2.x;
    end

    // split p into signed high and unsigned low halves
    always_comb begin
        for (int i = 0; i < 12; i++) begin
            n_lo[i] = qrv_pkg::LO_W'($signed({1'b0, w_pa[i][qrv_pkg::SPLIT-1:0]}))
                    * qrv_pkg::LO_W'(w_qa[i]);
            n_hi[i] = qrv_pkg::HI_W'($signed(w_pa[i][qrv_pkg::P_W-1:qrv_pkg::SPLIT]))
                    * qrv_pkg::HI_W'(w_qa[i]);
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_slo[c] = qrv_pkg::SUM_W'(r_lo[4*c])   + qrv_pkg::SUM_W'(r_lo[4*c+1])
                     + qrv_pkg::SUM_W'(r_lo[4*c+2]) - qrv_pkg::SUM_W'(r_lo[4*c+3]);
            n_shi[c] = qrv_pkg::SUM_W'(r_hi[4*c])   + qrv_pkg::SUM_W'(r_hi[4*c+1])
                     + qrv_pkg::SUM_W'(r_hi[4*c+2]) - qrv_pkg::SUM_W'(r_hi[4*c+3]);
            n_r[c] = (qrv_pkg::R_W'(r_shi[c]) <<< qrv_pkg::SPLIT) + qrv_pkg::R_W'(r_slo[c]);
        end
    end

    // floor shift and saturation
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r_r[c][qrv_pkg::R_W-1:qrv_pkg::OUT_SH+qrv_pkg::DATA_W-1]
                    == {(qrv_pkg::R_W-qrv_pkg::OUT_SH-qrv_pkg::DATA_W+1){r_r[c][qrv_pkg::R_W-1]}})
            begin
                w_rot[c] = r_r[c][qrv_pkg::OUT_SH+qrv_pkg::DATA_W-1:qrv_pkg::OUT_SH];
                w_sat[c] = 1'b0;
            end else begin
                w_rot[c] = r_r[c][qrv_pkg::R_W-1] ? qrv_pkg::Q_MIN : qrv_pkg::Q_MAX;
                w_sat[c] = 1'b1;
            end
        end
        n_out = '{rot_x: w_rot[0], rot_y: w_rot[1], rot_z: w_rot[2], saturated: |w_sat};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m   <= n_m;
        r_q1  <= n_q1;
        r_p   <= n_p;
        r_q2  <= r_q1;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_slo <= n_slo;
        r_shi <= n_shi;
        r_r   <= n_r;
        r_out <= n_out;
    end

    assign o_valid  = r_vld[qrv_pkg::LATENCY-1];
    assign o_result = r_out;

endmodule

// File: hdl/qrv_checker.sv
// port-level checks for quaternion_rotate_vector_core, bound into every instance of the core
// depends on qrv_pkg and quaternion_rotate_vector_core_assert.svh
`include "quaternion_rotate_vector_core_assert.svh"

module qrv_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input qrv_pkg::t_qrv_in  i_item,
    input logic              o_valid,
    input qrv_pkg::t_qrv_out o_result
);

    logic w_take;
    logic w_clip;
    logic w_vec_zero;
    logic w_rot_zero;

    assign w_take = start && !busy;

    assign w_clip = o_result.rot_x == qrv_pkg::Q_MAX || o_result.rot_x == qrv_pkg::Q_MIN
                 || o_result.rot_y == qrv_pkg::Q_MAX || o_result.rot_y == qrv_pkg::Q_MIN
                 || o_result.rot_z == qrv_pkg::Q_MAX || o_result.rot_z == qrv_pkg::Q_MIN;

    assign w_vec_zero = i_item.vec_x == '0 && i_item.vec_y == '0 && i_item.vec_z == '0;

    assign w_rot_zero = o_result.rot_x == '0 && o_result.rot_y == '0
                     && o_result.rot_z == '0;

    `QRV_CHECK_LAT(a_beat_out, w_take, o_valid, "accepted beat not delivered")

    `QRV_CHECK(a_no_extra, (o_valid |-> $past(w_take && i_rst_n, qrv_pkg::LATENCY)), "result without beat")

    `QRV_CHECK(a_sat_clip, ((o_valid && o_result.saturated) |-> w_clip), "flag without clipped value")

    `QRV_CHECK_LAT(a_zero_vec, w_take && w_vec_zero, w_rot_zero && !o_result.saturated, "zero vector not kept")

endmodule

bind quaternion_rotate_vector_core qrv_checker u_qrv_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_valid  (o_valid),
    .o_result (o_result)
);

// File: tb/quaternion_rotate_vector_core_tb.sv
// testbench for quaternion_rotate_vector_core: directed corners, then random beats
// a built-in predictor checks every result beat in order; depends on qrv_pkg and the core
`timescale 1ns / 1ps

module quaternion_rotate_vector_core_tb;
    import qrv_pkg::*;

    localparam int unsigned STALL_LIMIT = 1000;
    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh4000_0000;
    localparam logic signed [DATA_W-1:0] Q_HALF_SQRT2 = 32'sd759250125;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_qrv_in   i_item;
    logic      o_valid;
    t_qrv_out  o_result;

    t_qrv_out  rot_expected[$];
    t_qrv_out  rot_want;
    int        mismatches;
    int        beats_in;
    int        beats_out;
    int        beats_sat;
    int        quiet_cycles;

    quaternion_rotate_vector_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [DATA_W-1:0] clip_q16(input logic signed [127:0] acc,
                                                          inout logic clipped);
        logic signed [127:0] floored;
        floored = acc >>> OUT_SH;
        if (floored > Q_MAX) begin
            clipped = 1'b1;
            return Q_MAX;
        end
        if (floored < Q_MIN) begin
            clipped = 1'b1;
            return Q_MIN;
        end
        return floored[DATA_W-1:0];
    endfunction

    function automatic t_qrv_out rotate_predict(input t_qrv_in it);
        logic signed [127:0] qx, qy, qz, qw, vx, vy, vz;
        logic signed [127:0] pw, px, py, pz, rx, ry, rz;
        logic                clipped;
        t_qrv_out            res;
        qx = it.quat_x;
        qy = it.quat_y;
        qz = it.quat_z;
        qw = it.quat_w;
        vx = it.vec_x;
        vy = it.vec_y;
        vz = it.vec_z;
        // conj(q) * (v, 0)
        pw = qx * vx + qy * vy + qz * vz;
        px = qw * vx - qy * vz + qz * vy;
        py = qw * vy - qz * vx + qx * vz;
        pz = qw * vz - qx * vy + qy * vx;
        // times q, vector part
        rx = pw * qx + px * qw + py * qz - pz * qy;
        ry = pw * qy + py * qw + pz * qx - px * qz;
        rz = pw * qz + pz * qw + px * qy - py * qx;
        clipped = 1'b0;
        res.rot_x = clip_q16(rx, clipped);
        res.rot_y = clip_q16(ry, clipped);
        res.rot_z = clip_q16(rz, clipped);
        res.saturated = clipped;
        return res;
    endfunction

    // accepted beats in, result beats out, compared in order
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                beats_out++;
                if (o_result.saturated) beats_sat++;
                if (rot_expected.size() == 0) begin
                    mismatches++;
                    $display("%0t unexpected result beat %h", $time, o_result);
                end else begin
                    rot_want = rot_expected.pop_front();
                    if (o_result.rot_x !== rot_want.rot_x) begin
                        mismatches++;
                        $display("%0t rot_x expected %h actual %h", $time,
                                 rot_want.rot_x, o_result.rot_x);
                    end
                    if (o_result.rot_y !== rot_want.rot_y) begin
                        mismatches++;
                        $display("%0t rot_y expected %h actual %h", $time,
                                 rot_want.rot_y, o_result.rot_y);
                    end
                    if (o_result.rot_z !== rot_want.rot_z) begin
                        mismatches++;
                        $display("%0t rot_z expected %h actual %h", $time,
                                 rot_want.rot_z, o_result.rot_z);
                    end
                    if (o_result.saturated !== rot_want.saturated) begin
                        mismatches++;
                        $display("%0t saturated expected %b actual %b", $time,
                                 rot_want.saturated, o_result.saturated);
                    end
                end
            end
            if (start && !busy) begin
                beats_in++;
                rot_expected.push_back(rotate_predict(i_item));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_beat(input t_qrv_in it, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic release_start();
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task automatic wait_drained();
        while (rot_expected.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_qrv_in pack_item(input logic signed [DATA_W-1:0] qx, qy, qz, qw,
                                          input logic signed [DATA_W-1:0] vx, vy, vz);
        t_qrv_in it;
        it.quat_x = qx;
        it.quat_y = qy;
        it.quat_z = qz;
        it.quat_w = qw;
        it.vec_x  = vx;
        it.vec_y  = vy;
        it.vec_z  = vz;
        return it;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_field(input int bits);
        logic signed [DATA_W-1:0] raw;
        raw = $urandom;
        return raw >>> (DATA_W - bits);
    endfunction

    // random unit quaternion scaled to Q1.30, with a random vector
    function automatic t_qrv_in rand_rotation();
        real     c[4];
        real     norm;
        t_qrv_in it;
        norm = 0.0;
        for (int k = 0; k < 4; k++) begin
            c[k] = ($itor($urandom_range(2000000)) - 1000000.0) / 1000000.0;
            norm = norm + c[k] * c[k];
        end
        if (norm < 1.0e-6) begin
            c[3] = 1.0;
            norm = 1.0;
        end
        norm = $sqrt(norm);
        it.quat_x = $rtoi(1073741824.0 * c[0] / norm);
        it.quat_y = $rtoi(1073741824.0 * c[1] / norm);
        it.quat_z = $rtoi(1073741824.0 * c[2] / norm);
        it.quat_w = $rtoi(1073741824.0 * c[3] / norm);
        it.vec_x  = rand_field($urandom_range(1, 32));
        it.vec_y  = rand_field($urandom_range(1, 32));
        it.vec_z  = rand_field($urandom_range(1, 32));
        return it;
    endfunction

    function automatic t_qrv_in rand_item();
        t_qrv_in it;
        int      kind;
        kind = $urandom_range(9);
        if (kind < 6) begin
            it = rand_rotation();
        end else if (kind < 9) begin
            it = pack_item(rand_field($urandom_range(1, 32)), rand_field($urandom_range(1, 32)),
                           rand_field($urandom_range(1, 32)), rand_field($urandom_range(1, 32)),
                           rand_field($urandom_range(1, 32)), rand_field($urandom_range(1, 32)),
                           rand_field($urandom_range(1, 32)));
        end else begin
            it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end
        return it;
    endfunction

    task automatic test_extreme_fields();
        send_beat(pack_item(0, 0, 0, 0, 0, 0, 0), 0);
        send_beat(pack_item(0, 0, 0, Q_ONE, 32'sh0001_0000, -32'sh0001_0000, 12345), 0);
        send_beat(pack_item(0, 0, 0, Q_ONE, Q_MAX, Q_MIN, -1), 0);
        send_beat(pack_item(Q_ONE, 0, 0, 0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000), 0);
        send_beat(pack_item(0, 0, Q_HALF_SQRT2, Q_HALF_SQRT2, 32'sh0003_0000, -32'sh0002_8000,
                            32'sh7000_0000), 0);
        // tiny products: floor goes toward minus infinity
        send_beat(pack_item(0, 0, 0, 1, -1, 1, -1), 0);
        send_beat(pack_item(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX), 0);
        send_beat(pack_item(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN), 0);
        send_beat(pack_item(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX), 0);
        send_beat(pack_item(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN), 0);
        send_beat(pack_item(0, 0, 0, Q_MIN, Q_MAX, Q_MIN, 1), 0);
        send_beat(pack_item(Q_MAX, 0, 0, 0, Q_MIN, Q_MAX, Q_MIN), 0);
        send_beat(pack_item(Q_ONE, Q_ONE, Q_ONE, Q_ONE, 32'sh2000_0000, -32'sh2000_0000,
                            32'sh0000_1000), 0);
        send_beat(pack_item(-1, -1, -1, -1, -1, -1, -1), 0);
        send_beat({7{32'h5555_5555}}, 0);
        send_beat({7{32'hAAAA_AAAA}}, 0);
        release_start();
    endtask

    task automatic test_random_rotations(input int count, input int idle_pct);
        for (int k = 0; k < count; k++) send_beat(rand_item(), idle_pct);
        release_start();
    endtask

    task automatic test_drain_pause();
        for (int k = 0; k < 70; k++) send_beat(rand_item(), 20);
        release_start();
        wait_drained();
        for (int k = 0; k < 70; k++) send_beat(rand_item(), 20);
        release_start();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_item       = '0;
        mismatches   = 0;
        beats_in     = 0;
        beats_out    = 0;
        beats_sat    = 0;
        quiet_cycles = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extreme_fields();
        test_random_rotations(150, 0);
        test_random_rotations(150, 46);
        test_random_rotations(150, 35);
        test_drain_pause();

        wait_drained();
        repeat (LATENCY + 4) @(posedge i_clk);
        $display("rotation beats sent %0d, results checked %0d, %0d of them clipped",
                 beats_in, beats_out, beats_sat);
        $display("idle mixes 0/46/35 percent plus one full drain pause, %0d mismatches",
                 mismatches);
        if (mismatches == 0 && rot_expected.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
